// ===== hw/rtl/pnc_pkg.sv =====
// Shared types, constants and helper functions for the Pauli noise channel sampler.
// Used by every module of the block; has no dependencies of its own.
package pnc_pkg;

  // Field widths of one item.
  localparam int QUBIT_BITS    = 12;
  localparam int LOCATION_BITS = 16;
  localparam int FRACTION_BITS = 32;

  localparam int FUNC_W    = 1;
  localparam int CHANNEL_W = 3;
  localparam int SLOT_W    = 4;
  localparam int BASIS_W   = 2;
  localparam int PROB_W    = FRACTION_BITS + 1;

  // Probability table: fifteen slots, plus index width for walking them.
  localparam int NUM_SLOTS = 15;
  localparam int IDX_W     = 4;

  // Accumulator width: holds fifteen probabilities or fifteen times a draw.
  localparam int ACC_W = FRACTION_BITS + 4;

  // Input stream packing (tdata, lowest field first).
  localparam int IN_LOC_LSB   = 0;
  localparam int IN_QA_LSB    = IN_LOC_LSB + LOCATION_BITS;
  localparam int IN_QB_LSB    = IN_QA_LSB + QUBIT_BITS;
  localparam int IN_U_LSB     = IN_QB_LSB + QUBIT_BITS;
  localparam int IN_SLOT_LSB  = IN_U_LSB + FRACTION_BITS;
  localparam int IN_PROB_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_FIELDS_W  = IN_PROB_LSB + PROB_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = FUNC_W + CHANNEL_W;

  // Output stream packing (tdata, lowest field first).
  localparam int OUT_LOC_LSB   = 0;
  localparam int OUT_QUBIT_LSB = OUT_LOC_LSB + LOCATION_BITS;
  localparam int OUT_BASIS_LSB = OUT_QUBIT_LSB + QUBIT_BITS;
  localparam int OUT_FIELDS_W  = OUT_BASIS_LSB + BASIS_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Probability one in fixed point.
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRACTION_BITS;

  // Item kinds.
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

  // Channel kinds.
  localparam logic [CHANNEL_W-1:0] CH_X_ERR  = 3'd0;
  localparam logic [CHANNEL_W-1:0] CH_Y_ERR  = 3'd1;
  localparam logic [CHANNEL_W-1:0] CH_Z_ERR  = 3'd2;
  localparam logic [CHANNEL_W-1:0] CH_DEPOL1 = 3'd3;
  localparam logic [CHANNEL_W-1:0] CH_PAULI1 = 3'd4;
  localparam logic [CHANNEL_W-1:0] CH_DEPOL2 = 3'd5;
  localparam logic [CHANNEL_W-1:0] CH_PAULI2 = 3'd6;

  // Pauli codes as used in pair factors; the basis output is code minus one.
  localparam logic [BASIS_W-1:0] PAULI_I = 2'd0;
  localparam logic [BASIS_W-1:0] PAULI_X = 2'd1;
  localparam logic [BASIS_W-1:0] BASIS_X = 2'd0;
  localparam logic [BASIS_W-1:0] BASIS_Z = 2'd2;

  // Last index walked by the three-way and fifteen-way channels.
  localparam logic [IDX_W-1:0] LIMIT_ONE = IDX_W'(2);
  localparam logic [IDX_W-1:0] LIMIT_TWO = IDX_W'(NUM_SLOTS - 1);

  // Shared arithmetic unit operations.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic [ACC_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             flag;
  } alu_rsp_t;

  // Pair factors of the two-qubit channels: index k stands for k+1 in base 4,
  // high digit on the first qubit, low digit on the second. Indexes past the
  // table clamp to the last entry.
  function automatic logic [2*BASIS_W-1:0] pair_codes(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] k;
    logic [IDX_W:0]   t;
    k = (idx > LIMIT_TWO) ? LIMIT_TWO : idx;
    t = {1'b0, k} + (IDX_W+1)'(1);
    return t[2*BASIS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/pnc_prob_table.sv =====
// Fifteen-slot probability table with saturating writes.
// Depends on pnc_pkg for widths and the value of one.
module pnc_prob_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [pnc_pkg::SLOT_W-1:0] wr_slot,
  input  logic [pnc_pkg::PROB_W-1:0] wr_prob,
  input  logic [pnc_pkg::SLOT_W-1:0] rd_addr,
  output logic [pnc_pkg::PROB_W-1:0] rd_prob
);
  import pnc_pkg::*;

  logic [PROB_W-1:0] prob_r [NUM_SLOTS];
  logic [PROB_W-1:0] prob_sat;

  // Values above one are held at one.
  assign prob_sat = (wr_prob > PROB_ONE) ? PROB_ONE : wr_prob;

  // Writes to the slot past the table are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        prob_r[i] <= '0;
      end
    end else if (wr_en && (wr_slot < SLOT_W'(NUM_SLOTS))) begin
      prob_r[wr_slot] <= prob_sat;
    end
  end

  assign rd_prob = (rd_addr < SLOT_W'(NUM_SLOTS)) ? prob_r[rd_addr] : '0;

endmodule

// ===== hw/rtl/pnc_alu.sv =====
// Shared add/subtract and compare unit used by the sampling sequencer.
// Depends on pnc_pkg for the request and response structs.
module pnc_alu (
  input  pnc_pkg::alu_req_t req,
  output pnc_pkg::alu_rsp_t rsp
);
  import pnc_pkg::*;

  logic [ACC_W:0] add_w;
  logic [ACC_W:0] sub_w;

  assign add_w = {1'b0, req.a} + {1'b0, req.b};
  assign sub_w = {1'b0, req.a} - {1'b0, req.b};

  // Add compares the third operand against the sum; subtract reports a >= b.
  always_comb begin
    unique case (req.op)
      ALU_ADD: begin
        rsp.res  = add_w[ACC_W-1:0];
        rsp.flag = req.c < add_w[ACC_W-1:0];
      end
      ALU_SUB: begin
        rsp.res  = sub_w[ACC_W-1:0];
        rsp.flag = !sub_w[ACC_W];
      end
      default: begin
        rsp.res  = '0;
        rsp.flag = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pnc_seq.sv =====
// Sequencer that steps the shared arithmetic unit through one sample item
// and presents the fired Paulis. Depends on pnc_pkg.
module pnc_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  // Accepted sample item
  input  logic                              in_ready,
  input  logic                              in_start,
  input  logic [pnc_pkg::CHANNEL_W-1:0]     in_channel,
  input  logic [pnc_pkg::LOCATION_BITS-1:0] in_location,
  input  logic [pnc_pkg::QUBIT_BITS-1:0]    in_qubit_a,
  input  logic [pnc_pkg::QUBIT_BITS-1:0]    in_qubit_b,
  input  logic [pnc_pkg::FRACTION_BITS-1:0] in_uniform,
  output logic                              idle,
  // Probability table read
  output logic [pnc_pkg::SLOT_W-1:0]        tbl_addr,
  input  logic [pnc_pkg::PROB_W-1:0]        tbl_prob,
  // Shared unit
  output pnc_pkg::alu_req_t                 alu_req,
  input  pnc_pkg::alu_rsp_t                 alu_rsp,
  // Result item
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pnc_pkg::LOCATION_BITS-1:0] out_location,
  output logic [pnc_pkg::QUBIT_BITS-1:0]    out_qubit,
  output logic [pnc_pkg::BASIS_W-1:0]       out_basis,
  output logic                              out_last
);
  import pnc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACCUM,
    ST_EMIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CHANNEL_W-1:0]     chan_r, chan_nxt;
  logic [LOCATION_BITS-1:0] loc_r, loc_nxt;
  logic [QUBIT_BITS-1:0]    qa_r, qa_nxt;
  logic [QUBIT_BITS-1:0]    qb_r, qb_nxt;
  logic [FRACTION_BITS-1:0] u_r, u_nxt;
  logic [ACC_W-1:0]         work_r, work_nxt;
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic                     pend_r, pend_nxt;
  logic [BASIS_W-1:0]       pend_code_r, pend_code_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [LOCATION_BITS-1:0] out_loc_r, out_loc_nxt;
  logic [QUBIT_BITS-1:0]    out_qubit_r, out_qubit_nxt;
  logic [BASIS_W-1:0]       out_basis_r, out_basis_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     two_qubit;
  logic [IDX_W-1:0]         chan_lim;
  logic                     fin;
  logic [IDX_W-1:0]         fin_idx;
  logic [BASIS_W-1:0]       fin_ca;
  logic [BASIS_W-1:0]       fin_cb;
  logic [2*BASIS_W-1:0]     pair_w;

  assign two_qubit = (chan_r == CH_DEPOL2) || (chan_r == CH_PAULI2);
  assign chan_lim  = two_qubit ? LIMIT_TWO : LIMIT_ONE;
  assign pair_w    = pair_codes(fin_idx);

  // Table address: slot zero except while walking cumulative sums.
  assign tbl_addr = (state_r == ST_ACCUM) ? k_r : '0;

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.c  = ACC_W'(u_r);
    unique case (state_r)
      ST_IDLE: begin
        // Scale the draw on acceptance: 15u = 16u - u, 3u = 2u + u.
        if (in_channel == CH_DEPOL2) begin
          alu_req.op = ALU_SUB;
          alu_req.a  = ACC_W'(in_uniform) << 4;
        end else begin
          alu_req.a  = ACC_W'(in_uniform) << 1;
        end
        alu_req.b = ACC_W'(in_uniform);
      end
      ST_CHECK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ACC_W'(u_r);
        alu_req.b  = ACC_W'(tbl_prob);
      end
      ST_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = work_r;
        alu_req.b  = ACC_W'(tbl_prob);
      end
      ST_ACCUM: begin
        alu_req.a = work_r;
        alu_req.b = ACC_W'(tbl_prob);
      end
      ST_EMIT: begin
        alu_req.a = '0;
      end
      default: begin
        alu_req.a = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    loc_nxt       = loc_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    u_nxt         = u_r;
    work_nxt      = work_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    pend_code_nxt = pend_code_r;
    out_valid_nxt = out_valid_r;
    out_loc_nxt   = out_loc_r;
    out_qubit_nxt = out_qubit_r;
    out_basis_nxt = out_basis_r;
    out_last_nxt  = out_last_r;
    fin           = 1'b0;
    fin_idx       = k_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_start) begin
          chan_nxt = in_channel;
          loc_nxt  = in_location;
          qa_nxt   = in_qubit_a;
          qb_nxt   = in_qubit_b;
          u_nxt    = in_uniform;
          work_nxt = alu_rsp.res;
          k_nxt    = '0;
          priority if ((in_channel == CH_PAULI1) || (in_channel == CH_PAULI2)) begin
            work_nxt  = '0;
            state_nxt = ST_ACCUM;
          end else if (in_channel <= CH_DEPOL2) begin
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CHECK: begin
        // Nothing fires unless the draw lies below the first slot.
        priority if (alu_rsp.flag) begin
          state_nxt = ST_IDLE;
        end else if (chan_r <= CH_Z_ERR) begin
          fin = 1'b1;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // One restoring-division step per cycle, quotient clamped.
        if (alu_rsp.flag && (k_r != chan_lim)) begin
          work_nxt = alu_rsp.res;
          k_nxt    = k_r + IDX_W'(1);
        end else begin
          fin = 1'b1;
        end
      end
      ST_ACCUM: begin
        // Add one slot to the running sum and test the draw against it.
        priority if (alu_rsp.flag) begin
          fin = 1'b1;
        end else if (k_r == chan_lim) begin
          state_nxt = ST_IDLE;
        end else begin
          work_nxt = alu_rsp.res;
          k_nxt    = k_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (pend_r) begin
            out_qubit_nxt = qb_r;
            out_basis_nxt = pend_code_r - BASIS_W'(1);
            out_last_nxt  = 1'b1;
            pend_nxt      = 1'b0;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Factor codes of the selected outcome.
    priority if (chan_r <= CH_Z_ERR) begin
      fin_ca = chan_r[BASIS_W-1:0] + BASIS_W'(1);
      fin_cb = PAULI_I;
    end else if (two_qubit) begin
      fin_ca = pair_w[2*BASIS_W-1:BASIS_W];
      fin_cb = pair_w[BASIS_W-1:0];
    end else begin
      fin_ca = k_r[BASIS_W-1:0] + BASIS_W'(1);
      fin_cb = PAULI_I;
    end

    // Load the first fired Pauli; a second one waits in the pending slot.
    if (fin) begin
      state_nxt     = ST_EMIT;
      out_valid_nxt = 1'b1;
      out_loc_nxt   = loc_r;
      if (fin_ca != PAULI_I) begin
        out_qubit_nxt = qa_r;
        out_basis_nxt = fin_ca - BASIS_W'(1);
        out_last_nxt  = (fin_cb == PAULI_I);
        pend_nxt      = (fin_cb != PAULI_I);
        pend_code_nxt = fin_cb;
      end else begin
        out_qubit_nxt = qb_r;
        out_basis_nxt = fin_cb - BASIS_W'(1);
        out_last_nxt  = 1'b1;
        pend_nxt      = 1'b0;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_r      <= '0;
      loc_r       <= '0;
      qa_r        <= '0;
      qb_r        <= '0;
      u_r         <= '0;
      work_r      <= '0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      pend_code_r <= PAULI_I;
      out_valid_r <= 1'b0;
      out_loc_r   <= '0;
      out_qubit_r <= '0;
      out_basis_r <= BASIS_X;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      loc_r       <= loc_nxt;
      qa_r        <= qa_nxt;
      qb_r        <= qb_nxt;
      u_r         <= u_nxt;
      work_r      <= work_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      pend_code_r <= pend_code_nxt;
      out_valid_r <= out_valid_nxt;
      out_loc_r   <= out_loc_nxt;
      out_qubit_r <= out_qubit_nxt;
      out_basis_r <= out_basis_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // The ready input only qualifies starts already; idle tells the top level.
  assign idle         = (state_r == ST_IDLE) && in_ready;
  assign out_valid    = out_valid_r;
  assign out_location = out_loc_r;
  assign out_qubit    = out_qubit_r;
  assign out_basis    = out_basis_r;
  assign out_last     = out_last_r;

endmodule

// ===== hw/rtl/pauli_noise_channel_sampler.sv =====
// Top level of the Pauli noise channel sampler: stream ports, field packing.
// Depends on pnc_pkg, pnc_prob_table, pnc_alu and pnc_seq.
//
// The block takes one input item at a time. A write item (tuser func = 0)
// loads one probability slot in the cycle it is accepted and gives no result;
// the next item may follow in the next cycle. A sample item is worked on by a
// small sequencer that drives one shared add/subtract-compare unit, one step
// per cycle: after acceptance, a fixed X, Y or Z channel needs one compare,
// one-qubit depolarizing up to 4 steps, the three-way channel up to 3, two-
// qubit depolarizing up to 16 (one compare plus up to 15 subtract steps of
// the quotient) and the fifteen-way channel up to 15 running-sum steps. Each
// fired Pauli is then held on the output until it is taken, and in_tready rises
// again the cycle after the last result item is taken. A sample item that
// fires nothing returns to ready right after its last step. There is no
// clearing pass: reset clears the fifteen slots at once.
module pauli_noise_channel_sampler (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // location, qubit_a, qubit_b, uniform, slot, prob (lowest bit up), zero fill
  input  logic [pnc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func, channel (lowest bit up)
  input  logic [pnc_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fired_location, fired_qubit, basis (lowest bit up), zero fill
  output logic [pnc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import pnc_pkg::*;

  logic                     in_fire;
  logic [FUNC_W-1:0]        in_func;
  logic [CHANNEL_W-1:0]     in_channel;
  logic [LOCATION_BITS-1:0] in_location;
  logic [QUBIT_BITS-1:0]    in_qubit_a;
  logic [QUBIT_BITS-1:0]    in_qubit_b;
  logic [FRACTION_BITS-1:0] in_uniform;
  logic [SLOT_W-1:0]        in_slot;
  logic [PROB_W-1:0]        in_prob;
  logic                     seq_idle;
  logic [SLOT_W-1:0]        tbl_addr;
  logic [PROB_W-1:0]        tbl_prob;
  alu_req_t                 alu_req;
  alu_rsp_t                 alu_rsp;
  logic [LOCATION_BITS-1:0] res_location;
  logic [QUBIT_BITS-1:0]    res_qubit;
  logic [BASIS_W-1:0]       res_basis;

  // Unpack the input item.
  assign in_func     = in_tuser[FUNC_W-1:0];
  assign in_channel  = in_tuser[FUNC_W +: CHANNEL_W];
  assign in_location = in_tdata[IN_LOC_LSB +: LOCATION_BITS];
  assign in_qubit_a  = in_tdata[IN_QA_LSB +: QUBIT_BITS];
  assign in_qubit_b  = in_tdata[IN_QB_LSB +: QUBIT_BITS];
  assign in_uniform  = in_tdata[IN_U_LSB +: FRACTION_BITS];
  assign in_slot     = in_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_prob     = in_tdata[IN_PROB_LSB +: PROB_W];

  assign in_tready = seq_idle;
  assign in_fire   = in_tvalid && in_tready;

  pnc_prob_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && (in_func == FUNC_WRITE)),
    .wr_slot (in_slot),
    .wr_prob (in_prob),
    .rd_addr (tbl_addr),
    .rd_prob (tbl_prob)
  );

  pnc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  pnc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (1'b1),
    .in_start     (in_fire && (in_func == FUNC_SAMPLE)),
    .in_channel   (in_channel),
    .in_location  (in_location),
    .in_qubit_a   (in_qubit_a),
    .in_qubit_b   (in_qubit_b),
    .in_uniform   (in_uniform),
    .idle         (seq_idle),
    .tbl_addr     (tbl_addr),
    .tbl_prob     (tbl_prob),
    .alu_req      (alu_req),
    .alu_rsp      (alu_rsp),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_location (res_location),
    .out_qubit    (res_qubit),
    .out_basis    (res_basis),
    .out_last     (out_tlast)
  );

  // Pack the result item.
  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_LOC_LSB +: LOCATION_BITS] = res_location;
    out_tdata[OUT_QUBIT_LSB +: QUBIT_BITS]  = res_qubit;
    out_tdata[OUT_BASIS_LSB +: BASIS_W]     = res_basis;
  end

endmodule

// ===== hw/rtl/pnc_checker.sv =====
// Port-level checks for the Pauli noise channel sampler, bound to its top level.
// Depends on pnc_pkg for field positions and codes.
module pnc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pnc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pnc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import pnc_pkg::*;

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // One item at a time: never ready for input while a result is shown.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result item is pending");

  // Fired basis is always X, Y or Z.
  a_basis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_BASIS_LSB +: BASIS_W] <= BASIS_Z))
    else $error("result item carries an invalid basis");

  // A write item produces no result and leaves the block ready.
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[FUNC_W-1:0] == FUNC_WRITE)
    |=> in_tready && !out_tvalid)
    else $error("write item did not return straight to ready");

  // After a non-last result is taken the next one follows; after the last, ready.
  a_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> (out_tvalid && out_tlast) || (in_tready && !out_tvalid))
    else $error("wrong follow-up after a result item was taken");

endmodule

bind pauli_noise_channel_sampler pnc_checker u_pnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
